// ===== rtl/core/pip_pkg.sv =====
package pip_pkg;

  // request codes on in_req_type
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // register index of vertex_count
  localparam logic REG_VCOUNT = 1'b0;

  // controller to datapath
  typedef struct packed {
    logic wr_en;     // write the vertex of the current input transfer
    logic pt_load;   // capture the query point
    logic clr;       // clear the crossing flag
    logic rd_en;     // read one vertex
    logic rd_first;  // this read only primes the previous-vertex register
    logic res_load;  // copy the crossing flag into the result register
  } pip_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;      // edge pipeline still holds work
  } pip_sts_t;

endpackage

// ===== rtl/core/pip_ctrl.sv =====
module pip_ctrl import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_req_type,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  logic [$clog2(MAX_VERTICES+1)-1:0] vert_n,
  output pip_cmd_t                          cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
  input  pip_sts_t                          sts
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES+1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FINISH} state_t;

  state_t          state_r, state_nxt;
  logic            first_r, first_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [NW-1:0]   n_m1;
  logic [AW-1:0]   last;
  logic            ge3;
  logic            slot_free;

  assign n_m1      = vert_n - 1'b1;
  assign last      = n_m1[AW-1:0];
  assign ge3       = (32'(vert_n) >= 32'd3);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    rd_addr       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.pt_load = 1'b1;
            cmd.clr     = 1'b1;
            if (ge3) begin
              state_nxt = S_WALK;
              first_nxt = 1'b1;
            end else begin
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_WALK: begin
        cmd.rd_en = 1'b1;
        if (first_r) begin
          // closing edge starts from the last vertex
          rd_addr      = last;
          cmd.rd_first = 1'b1;
          first_nxt    = 1'b0;
          cnt_nxt      = '0;
        end else if (cnt_r == last) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = AW'(cnt_r + 1'b1);
        end
      end
      S_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !cmd.rd_en)
    else $error("vertex write and read in the same cycle");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && !first_r) |-> (cnt_r <= last))
    else $error("edge counter ran past the last vertex");

  a_small_poly: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_req_type == REQ_QUERY && !ge3)
      |=> (state_r == S_FINISH))
    else $error("degenerate polygon query did not skip the walk");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && slot_free) |=> out_valid_r)
    else $error("finished query did not raise a result");
`endif

endmodule

// ===== rtl/core/pip_dpath.sv =====
module pip_dpath import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pip_cmd_t                        cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  input  logic [5:0]                      in_vertex_index,
  input  logic signed [15:0]              in_coord_x,
  input  logic signed [15:0]              in_coord_y,
  output pip_sts_t                        sts,
  output logic                            inside_res
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int PW = 2*CW + 2;

  logic [2*CW-1:0]       mem [MAX_VERTICES];
  logic [AW+5:0]         idx_ext;
  logic                  idx_ok;

  logic signed [CW-1:0]  px_r, py_r;
  logic [2*CW-1:0]       rd_data_r;
  logic                  rd_v_r, rd_first_r;
  logic [2*CW-1:0]       prev_r;

  logic signed [CW-1:0]  xi, yi, xj, yj;
  logic signed [CW:0]    dy, dpx, dx, dpy;
  logic                  straddle;

  logic signed [PW-1:0]  lhs_r, rhs_r;
  logic                  dy_pos_r, edge_v_r, b_v_r;
  logic                  left;
  logic                  flag_r, res_r;

  assign idx_ext = {{AW{1'b0}}, in_vertex_index};
  assign idx_ok  = (32'(in_vertex_index) < MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && idx_ok) begin
      mem[idx_ext[AW-1:0]] <= {in_coord_y[CW-1:0], in_coord_x[CW-1:0]};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pt_load) begin
      px_r <= in_coord_x[CW-1:0];
      py_r <= in_coord_y[CW-1:0];
    end
  end

  // edge stage: current vertex from the read register, previous one held
  assign xi = signed'(rd_data_r[CW-1:0]);
  assign yi = signed'(rd_data_r[2*CW-1:CW]);
  assign xj = signed'(prev_r[CW-1:0]);
  assign yj = signed'(prev_r[2*CW-1:CW]);

  assign straddle = (yi > py_r) != (yj > py_r);
  assign dy  = (CW+1)'(yj) - (CW+1)'(yi);
  assign dpx = (CW+1)'(px_r) - (CW+1)'(xi);
  assign dx  = (CW+1)'(xj) - (CW+1)'(xi);
  assign dpy = (CW+1)'(py_r) - (CW+1)'(yi);

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prev_r   <= rd_data_r;
      lhs_r    <= PW'(dpx) * PW'(dy);
      rhs_r    <= PW'(dx) * PW'(dpy);
      dy_pos_r <= (dy > 0);
      edge_v_r <= straddle && !rd_first_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r     <= 1'b0;
      rd_first_r <= 1'b0;
      b_v_r      <= 1'b0;
    end else begin
      rd_v_r     <= cmd.rd_en;
      rd_first_r <= cmd.rd_first;
      b_v_r      <= rd_v_r;
    end
  end

  // sense of the crossing test flips with the sign of dy
  assign left = dy_pos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      flag_r <= 1'b0;
    end else if (b_v_r && edge_v_r && left) begin
      flag_r <= !flag_r;
    end
    if (cmd.res_load) begin
      res_r <= flag_r;
    end
  end

  assign sts.busy   = rd_v_r || b_v_r;
  assign inside_res = res_r;

endmodule

// ===== rtl/core/point_in_polygon_test.sv =====
// channel  | handshake                 | payload
// in       | in_valid / in_stall       | in_req_type, in_vertex_index, in_coord_x, in_coord_y
// out      | out_valid / out_stall     | out_inside_res
// config   | psel, penable, pwrite     | paddr, pwdata, prdata, pready
//
// a load writes its vertex as it is taken; a query reads the vertex memory through its single
// read port, one vertex per cycle, then drains the edge pipeline; below three vertices it skips both
// synchronous active-low reset clears control and vertex_count, not the vertex memory
// a finished result waits in the output register while the next transfer is taken in
// the finish cycle of a query also waits while an earlier result is still stalled
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [5:0]         in_vertex_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_inside_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES+1);

  logic [6:0]    vcount_r;
  logic [NW-1:0] vert_n;
  logic          reg_sel;
  pip_cmd_t      cmd;
  pip_sts_t      sts;
  logic [AW-1:0] rd_addr;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_VCOUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      vcount_r <= pwdata[6:0];
    end
  end

  assign prdata = reg_sel ? {25'd0, vcount_r} : 32'd0;

  // count beyond capacity saturates
  assign vert_n = (32'(vcount_r) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_r);

  pip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .vert_n     (vert_n),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .sts        (sts)
  );

  pip_dpath #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .in_vertex_index(in_vertex_index),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .sts            (sts),
    .inside_res     (out_inside_res)
  );

endmodule

// ===== sim/pip_checker.sv =====
module pip_checker import pip_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_req_type,
  input  logic [5:0]         in_vertex_index,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_inside_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] VCOUNT_ADDR = {REG_VCOUNT, 2'b00};

  typedef struct {
    logic               in_poly;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } query_expect_t;

  logic signed [15:0] vert_x [MAX_VERTICES];
  logic signed [15:0] vert_y [MAX_VERTICES];
  logic [6:0]         vcount;
  query_expect_t      expected_flags_q [$];
  int                 mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // even-odd crossing test over the first vcount vertices (at most MAX_VERTICES), exact integer compare
  function automatic logic predict_inside(input logic signed [15:0] px,
                                          input logic signed [15:0] py);
    int     n;
    int     j;
    logic   flag;
    longint dy;
    longint lhs;
    longint rhs;
    n = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
    flag = 1'b0;
    if (n < 3) return 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      if ((vert_y[i] > py) != (vert_y[j] > py)) begin
        dy  = longint'(vert_y[j]) - longint'(vert_y[i]);
        lhs = (longint'(px) - longint'(vert_x[i])) * dy;
        rhs = (longint'(vert_x[j]) - longint'(vert_x[i])) *
              (longint'(py) - longint'(vert_y[i]));
        // comparison sense flips for a downward edge
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) flag = ~flag;
      end
      j = i;
    end
    return flag;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 200) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    query_expect_t head;
    query_expect_t fresh;
    if (!rst_n) begin
      vcount = '0;
      expected_flags_q.delete();
    end else begin
      // result side first so a same-edge input transfer cannot be matched
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_flags_q.size() == 0) begin
          report_mismatch($sformatf("result %b with no query waiting", out_inside_res));
        end else begin
          head = expected_flags_q.pop_front();
          if (out_inside_res !== head.in_poly)
            report_mismatch($sformatf("point (%0d,%0d) gave %b, expected %b",
                                      head.px, head.py, out_inside_res, head.in_poly));
        end
      end
      if (psel && penable && pwrite && pready && paddr == VCOUNT_ADDR)
        vcount = pwdata[6:0];
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (in_req_type == REQ_LOAD) begin
          if (in_vertex_index < MAX_VERTICES) begin
            vert_x[in_vertex_index] = in_coord_x;
            vert_y[in_vertex_index] = in_coord_y;
          end
        end else begin
          fresh.in_poly = predict_inside(in_coord_x, in_coord_y);
          fresh.px      = in_coord_x;
          fresh.py      = in_coord_y;
          expected_flags_q.push_back(fresh);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_flags_q.size();
  end

endmodule

// ===== sim/tb_point_in_polygon_test.sv =====
module tb_point_in_polygon_test import pip_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         LIMIT_CYCLES  = 1_000_000;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         HOLD_CYCLES   = 600;
  localparam int         PHASE_ITEMS   = 38;
  localparam logic [2:0] VCOUNT_ADDR   = {REG_VCOUNT, 2'b00};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [5:0]         in_vertex_index;
  logic signed [15:0] in_coord_x;
  logic signed [15:0] in_coord_y;
  logic               out_valid;
  logic               out_stall;
  logic               out_inside_res;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  int                 cycle_count = 0;
  logic               tx_calm;
  logic               rx_calm;
  logic               rx_hold;
  int                 win_cx;
  int                 win_cy;
  int                 win_span;
  int                 cur_n;
  logic signed [15:0] poly_x [64];
  logic signed [15:0] poly_y [64];
  int                 phase_counts [14] = '{64, 127, 3, 0, 5, 1, 2, 8, 16, 65, 4, 100, 33, 64};

  point_in_polygon_test u_dut (.*);
  pip_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [15:0] clamp_coord(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int idle_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int near_window(input int c);
    int reach;
    reach = win_span + win_span / 4;
    return c + int'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return -1;
      2: return 0;
      default: return 32767;
    endcase
  endfunction

  task automatic send_item(input logic req, input logic [5:0] idx, input int x, input int y);
    int gap;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_vertex_index <= idx;
    in_coord_x      <= clamp_coord(x);
    in_coord_y      <= clamp_coord(y);
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_vertex(input int idx, input int x, input int y);
    poly_x[idx] = clamp_coord(x);
    poly_y[idx] = clamp_coord(y);
    send_item(REQ_LOAD, 6'(idx), x, y);
  endtask

  // vertex_index is a don't-care on a query, so randomize it
  task automatic query_point(input int x, input int y);
    send_item(REQ_QUERY, 6'($urandom_range(0, 63)), x, y);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // loads leave nothing in the result queue, so give the pipeline time to empty
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= VCOUNT_ADDR;
    pwdata  <= ($urandom() & ~32'h7F) | 32'(value & 'h7F);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_n = (value > 64) ? 64 : value;
  endtask

  task automatic pick_window();
    win_cx = int'($urandom_range(0, 65535)) - 32768;
    win_cy = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 3))
      0: win_span = 8;
      1: win_span = 64;
      2: win_span = 1024;
      default: win_span = 32767;
    endcase
  endtask

  // either a jittered diamond around the window center or a random scatter
  task automatic rebuild_polygon(input int n);
    int   pos;
    int   a;
    int   jit;
    int   jx;
    int   jy;
    logic diamond;
    diamond = $urandom_range(0, 1);
    jit = win_span / 8;
    for (int k = 0; k < n; k++) begin
      if (!diamond) begin
        load_vertex(k, near_window(win_cx), near_window(win_cy));
      end else begin
        pos = (k * 4096) / n;
        a   = win_span * (pos % 1024) / 1024;
        jx  = int'($urandom_range(0, 2 * jit)) - jit;
        jy  = int'($urandom_range(0, 2 * jit)) - jit;
        case (pos / 1024)
          0: load_vertex(k, win_cx + win_span - a + jx, win_cy + a + jy);
          1: load_vertex(k, win_cx - a + jx, win_cy + win_span - a + jy);
          2: load_vertex(k, win_cx - win_span + a + jx, win_cy - a + jy);
          default: load_vertex(k, win_cx + a + jx, win_cy - win_span + a + jy);
        endcase
      end
    end
  endtask

  task automatic random_query();
    int k;
    int k2;
    int px;
    int py;
    k  = $urandom_range(0, (cur_n > 0) ? cur_n - 1 : 63);
    k2 = (cur_n > 0) ? (k + 1) % cur_n : (k + 1) % 64;
    px = near_window(win_cx);
    py = near_window(win_cy);
    case ($urandom_range(0, 9))
      5: py = poly_y[k];
      6: begin
        px = poly_x[k];
        if ($urandom_range(0, 1)) py = poly_y[k];
      end
      7: begin
        px = int'($urandom_range(0, 65535)) - 32768;
        py = int'($urandom_range(0, 65535)) - 32768;
      end
      8: begin
        px = extreme_coord();
        py = extreme_coord();
      end
      // near an edge midpoint
      9: begin
        px = (int'(poly_x[k]) + int'(poly_x[k2])) / 2;
        py = (int'(poly_y[k]) + int'(poly_y[k2])) / 2;
      end
      default: ;
    endcase
    query_point(px, py);
  endtask

  task automatic run_phase(input int count, input logic hold);
    settle();
    set_vertex_count(count);
    pick_window();
    tx_calm = hold || ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    if (cur_n >= 3 && $urandom_range(0, 1)) rebuild_polygon(cur_n);
    rx_hold = hold;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 1) && cur_n > 0)
          load_vertex($urandom_range(0, cur_n - 1), near_window(win_cx), near_window(win_cy));
        else
          load_vertex($urandom_range(0, 63), int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768);
      end else begin
        random_query();
      end
      if (!hold && $urandom_range(0, 39) == 0) wait_results();
    end
  endtask

  // result side: random stalls, calm stretches and one long hold-off
  initial begin
    int run;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin
    in_valid        = 1'b0;
    in_req_type     = REQ_LOAD;
    in_vertex_index = '0;
    in_coord_x      = '0;
    in_coord_y      = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_n           = 1'b0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    rx_hold         = 1'b0;
    cur_n           = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // vertex_count is still zero from reset, nothing is read
    query_point(-32768, -32768);
    query_point(32767, 32767);
    load_vertex(0, -32768, -32768);
    load_vertex(1, 32767, -32768);
    load_vertex(2, 32767, 32767);
    load_vertex(3, -32768, 32767);
    load_vertex(63, -1, -1);

    // two vertices never enclose anything
    settle();
    set_vertex_count(2);
    query_point(0, 0);

    settle();
    set_vertex_count(3);
    query_point(16384, -16384);
    query_point(-16384, 16384);
    query_point(0, 0);

    // full-range square: center, every side, two corners and a point near the center
    settle();
    set_vertex_count(4);
    query_point(0, 0);
    query_point(-32768, 0);
    query_point(32767, 0);
    query_point(0, -32768);
    query_point(0, 32767);
    query_point(-32768, -32768);
    query_point(32767, 32767);
    query_point(-1, -1);

    // every vertex written before any count above four
    pick_window();
    rebuild_polygon(64);
    foreach (phase_counts[p]) run_phase(phase_counts[p], p == 0);
    run_phase($urandom_range(0, 127), 1'b0);

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== point_in_polygon_test.f =====
rtl/core/pip_pkg.sv
rtl/core/pip_ctrl.sv
rtl/core/pip_dpath.sv
rtl/core/point_in_polygon_test.sv
sim/pip_checker.sv
sim/tb_point_in_polygon_test.sv
